// ----- design/iwm_pkg.sv -----
// Shared types and constants for the interarrival window median unit.
package iwm_pkg;

  localparam int unsigned IWM_WINDOW_DEF = 100;
  localparam int unsigned TIME_W         = 64;
  localparam int unsigned LOG_W          = 16;
  localparam int unsigned MANT_W         = 32;
  localparam int unsigned FRAC_BITS      = 20;
  localparam int unsigned EXP_W          = 7;
  localparam int unsigned NORM_STEPS     = 6;
  localparam int unsigned STEP_W         = 5;

  // ln 2 in Q0.32, rounded to nearest
  localparam logic [MANT_W-1:0] LN2_Q32  = 32'd2977044472;

  // request into the window engine
  typedef struct packed {
    logic              start;
    logic              push;
    logic [TIME_W-1:0] value;
  } win_req_t;

  // answer from the window engine
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] median;
  } win_rsp_t;

  // request into the log1p unit
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] x;
  } log_req_t;

  // answer from the log1p unit
  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] result;
  } log_rsp_t;

endpackage

// ----- design/iwm_log_unit.sv -----
// Iterative log1p in unsigned 6.10 fixed point around one shared 32x32 multiplier.
module iwm_log_unit
  import iwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  log_req_t req,
  output log_rsp_t rsp
);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQ   = 5'b00100,
    L_MUL  = 5'b01000,
    L_DONE = 5'b10000
  } lstate_t;

  lstate_t state_r, state_nxt;

  logic [TIME_W-1:0]    m_r, m_nxt;
  logic [5:0]           z_r, z_nxt;
  logic                 special_r, special_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [MANT_W-1:0]    t_r, t_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [LOG_W-1:0]     res_r, res_nxt;

  logic [6:0]           shamt;
  logic [TIME_W-1:0]    hi_mask;
  logic [EXP_W-1:0]     expo;
  logic [MANT_W-1:0]    mul_a, mul_b;
  logic [2*MANT_W-1:0]  prod;
  logic [MANT_W:0]      sq;
  logic [2*MANT_W-1:0]  rounded;

  // normalize step: shift by 32,16,8,4,2,1 when the top bits are clear
  assign shamt   = 7'd32 >> step_r[2:0];
  assign hi_mask = ~({TIME_W{1'b1}} >> shamt);
  assign expo    = special_r ? 7'd64 : (7'd63 - {1'b0, z_r});

  // the one multiplier: squaring steps, then scaling by ln 2
  always_comb begin
    mul_a = t_r;
    mul_b = t_r;
    if (state_r == L_MUL) begin
      mul_a = {{(MANT_W-EXP_W-FRAC_BITS){1'b0}}, expo, frac_r};
      mul_b = LN2_Q32;
    end
  end
  assign prod    = mul_a * mul_b;
  assign sq      = prod[2*MANT_W-1:MANT_W-1];
  assign rounded = prod + (64'd1 << 41);

  always_comb begin
    state_nxt   = state_r;
    m_nxt       = m_r;
    z_nxt       = z_r;
    special_nxt = special_r;
    step_nxt    = step_r;
    t_nxt       = t_r;
    frac_nxt    = frac_r;
    res_nxt     = res_r;
    case (state_r)
      // a new request may arrive in the same cycle that the previous result is shown
      L_IDLE, L_DONE: begin
        state_nxt = L_IDLE;
        if (req.start) begin
          special_nxt = &req.x;
          m_nxt       = (&req.x) ? {1'b1, {(TIME_W-1){1'b0}}} : req.x + 64'd1;
          z_nxt       = '0;
          step_nxt    = '0;
          state_nxt   = L_NORM;
        end
      end
      L_NORM: begin
        if ((m_r & hi_mask) == '0) begin
          m_nxt = m_r << shamt;
          z_nxt = z_r + shamt[5:0];
        end
        if (step_r == STEP_W'(NORM_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = L_SQ;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      L_SQ: begin
        // t enters as the normalized mantissa, Q1.31
        frac_nxt = {frac_r[FRAC_BITS-2:0], sq[MANT_W]};
        t_nxt    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        if (step_r == STEP_W'(FRAC_BITS - 1)) begin
          state_nxt = L_MUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      L_MUL: begin
        res_nxt   = rounded[41+LOG_W:42];
        state_nxt = L_DONE;
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
    // load mantissa when leaving normalization
    if (state_r == L_NORM && step_r == STEP_W'(NORM_STEPS - 1)) begin
      t_nxt    = m_nxt[TIME_W-1:TIME_W-MANT_W];
      frac_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    m_r       <= m_nxt;
    z_r       <= z_nxt;
    special_r <= special_nxt;
    step_r    <= step_nxt;
    t_r       <= t_nxt;
    frac_r    <= frac_nxt;
    res_r     <= res_nxt;
  end

  assign rsp.done   = (state_r == L_DONE);
  assign rsp.result = res_r;

endmodule

// ----- design/iwm_window.sv -----
// Interval window: arrival ring plus a sorted copy kept in order by a one-port sequencer.
module iwm_window
  import iwm_pkg::*;
#(
  parameter int unsigned WINDOW = IWM_WINDOW_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  win_req_t req,
  output win_rsp_t rsp
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [9:0] {
    W_IDLE     = 10'b0000000001,
    W_RING     = 10'b0000000010,
    W_RING_GET = 10'b0000000100,
    W_DEL_RD   = 10'b0000001000,
    W_DEL_CHK  = 10'b0000010000,
    W_INS      = 10'b0000100000,
    W_INS_CHK  = 10'b0001000000,
    W_MED_RD   = 10'b0010000000,
    W_MED_GET  = 10'b0100000000,
    W_DONE     = 10'b1000000000
  } wstate_t;

  wstate_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [TIME_W-1:0] val_r, val_nxt;
  logic [TIME_W-1:0] evict_r, evict_nxt;
  logic [TIME_W-1:0] median_r, median_nxt;

  logic [TIME_W-1:0] ring_mem [WINDOW];
  logic [TIME_W-1:0] ring_q;
  logic [TIME_W-1:0] srt_mem [WINDOW];
  logic [TIME_W-1:0] srt_q;

  logic              ring_we;
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr, s_raddr;
  logic [TIME_W-1:0] s_wdata;
  logic              full;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  count_inc;

  assign full      = (count_r == CNT_W'(WINDOW));
  assign idx_dec   = idx_r - 1'b1;
  assign count_inc = full ? count_r : count_r + 1'b1;

  // sequencer: on a push write the ring, evict from sorted copy once full, insert new value; then read median
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    wp_nxt     = wp_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    val_nxt    = val_r;
    evict_nxt  = evict_r;
    median_nxt = median_r;
    ring_we    = 1'b0;
    s_we       = 1'b0;
    s_waddr    = idx_r[IDX_W-1:0];
    s_wdata    = val_r;
    s_raddr    = idx_r[IDX_W-1:0];
    case (state_r)
      W_IDLE: begin
        if (req.start) begin
          val_nxt   = req.value;
          state_nxt = req.push ? W_RING : W_MED_RD;
        end
      end
      W_RING: begin
        ring_we = 1'b1;
        wp_nxt  = (wp_r == IDX_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
        if (full) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = W_RING_GET;
        end else begin
          idx_nxt   = count_r;
          state_nxt = W_INS;
        end
      end
      W_RING_GET: begin
        evict_nxt = ring_q;
        state_nxt = W_DEL_RD;
      end
      W_DEL_RD: begin
        state_nxt = W_DEL_CHK;
      end
      W_DEL_CHK: begin
        // close the gap left by one copy of the evicted value
        if (found_r) begin
          s_we    = 1'b1;
          s_waddr = idx_dec[IDX_W-1:0];
          s_wdata = srt_q;
        end else if (srt_q == evict_r) begin
          found_nxt = 1'b1;
        end
        if (idx_r == count_r - 1'b1) begin
          state_nxt = W_INS;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = W_DEL_RD;
        end
      end
      W_INS: begin
        // idx is the hole; walk it down past larger entries
        if (idx_r == '0) begin
          s_we      = 1'b1;
          s_waddr   = '0;
          count_nxt = count_inc;
          state_nxt = W_MED_RD;
        end else begin
          s_raddr   = idx_dec[IDX_W-1:0];
          state_nxt = W_INS_CHK;
        end
      end
      W_INS_CHK: begin
        s_we = 1'b1;
        if (srt_q > val_r) begin
          s_wdata   = srt_q;
          idx_nxt   = idx_dec;
          state_nxt = W_INS;
        end else begin
          count_nxt = count_inc;
          state_nxt = W_MED_RD;
        end
      end
      W_MED_RD: begin
        s_raddr = IDX_W'(count_r >> 1);
        if (count_r == '0) begin
          median_nxt = '0;
          state_nxt  = W_DONE;
        end else begin
          state_nxt = W_MED_GET;
        end
      end
      W_MED_GET: begin
        median_nxt = srt_q;
        state_nxt  = W_DONE;
      end
      W_DONE: begin
        state_nxt = W_IDLE;
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  // arrival ring, read before overwrite at the same slot
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= val_r;
    end
    ring_q <= ring_mem[wp_r];
  end

  // sorted copy
  always_ff @(posedge clk) begin
    if (s_we) begin
      srt_mem[s_waddr] <= s_wdata;
    end
    srt_q <= srt_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      count_r <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wp_r    <= wp_nxt;
    end
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    val_r    <= val_nxt;
    evict_r  <= evict_nxt;
    median_r <= median_nxt;
  end

  assign rsp.done   = (state_r == W_DONE);
  assign rsp.median = median_r;

endmodule

// ----- design/interarrival_window_median.sv -----
// Top level of the interarrival window median unit: interval, window update, logs, output.
// Each transaction carries one 64-bit timestamp and yields one result: the interval since
// the previous timestamp, the median of the most recent WINDOW positive intervals, and
// log1p of both in unsigned 6.10. One item is in flight at a time; in_tready is high only
// between items. A positive interval adds a walk past the larger sorted entries to insert
// it and, once the window is full, a pass over the sorted copy to remove the evicted
// interval. The time per item is set by this walk over the sorted copy of the window and
// by the 20 squaring steps of the shared multiplier in the log1p unit, run twice per item.
// A finished result waits in the output register while the next timestamp is already
// taken in.
module interarrival_window_median_unit
  import iwm_pkg::*;
#(
  parameter int unsigned WINDOW = IWM_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] event_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // [63:0] interval, [127:64] window_median,
                                   // [143:128] interval_log, [159:144] median_log
);

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_DIFF = 6'b000010,
    T_WIN  = 6'b000100,
    T_LOG1 = 6'b001000,
    T_LOG2 = 6'b010000,
    T_OUT  = 6'b100000
  } tstate_t;

  tstate_t state_r, state_nxt;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0] interval_r, interval_nxt;
  logic [TIME_W-1:0] median_r, median_nxt;
  logic [LOG_W-1:0]  ilog_r, ilog_nxt;
  logic [LOG_W-1:0]  mlog_r, mlog_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [159:0]      out_data_r, out_data_nxt;

  logic              later;
  logic [TIME_W-1:0] diff;
  win_req_t          win_req;
  win_rsp_t          win_rsp;
  log_req_t          log_req;
  log_rsp_t          log_rsp;

  assign later = (prev_r != '0) && (time_r > prev_r);
  assign diff  = time_r - prev_r;

  // item sequencer
  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    prev_nxt      = prev_r;
    interval_nxt  = interval_r;
    median_nxt    = median_r;
    ilog_nxt      = ilog_r;
    mlog_nxt      = mlog_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    win_req       = '0;
    log_req       = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      T_IDLE: begin
        if (in_tvalid) begin
          time_nxt  = in_tdata;
          state_nxt = T_DIFF;
        end
      end
      T_DIFF: begin
        interval_nxt  = later ? diff : '0;
        prev_nxt      = time_r;
        win_req.start = 1'b1;
        win_req.push  = later;
        win_req.value = diff;
        state_nxt     = T_WIN;
      end
      T_WIN: begin
        if (win_rsp.done) begin
          median_nxt    = win_rsp.median;
          log_req.start = 1'b1;
          log_req.x     = interval_r;
          state_nxt     = T_LOG1;
        end
      end
      T_LOG1: begin
        if (log_rsp.done) begin
          ilog_nxt      = log_rsp.result;
          log_req.start = 1'b1;
          log_req.x     = median_r;
          state_nxt     = T_LOG2;
        end
      end
      T_LOG2: begin
        if (log_rsp.done) begin
          mlog_nxt  = log_rsp.result;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {mlog_r, ilog_r, median_r, interval_r};
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    time_r     <= time_nxt;
    interval_r <= interval_nxt;
    median_r   <= median_nxt;
    ilog_r     <= ilog_nxt;
    mlog_r     <= mlog_nxt;
    out_data_r <= out_data_nxt;
  end

  iwm_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .rsp   (win_rsp)
  );

  iwm_log_unit u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (log_req),
    .rsp   (log_rsp)
  );

  assign in_tready  = (state_r == T_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- bench/iwm_median_checker.sv -----
// Checker for the interarrival window median unit: tracks both streams, predicts and compares.
`timescale 1ns / 100ps

module iwm_median_checker
  import iwm_pkg::*;
#(
  parameter int WINDOW = IWM_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] event_time
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,  // [63:0] interval, [127:64] window_median,
                                   // [143:128] interval_log, [159:144] median_log
  output int           fail_count,
  output int           pending
);

  localparam int EXP_DEPTH = 64;

  // one result transaction, laid out as on out_tdata (lowest field last)
  typedef struct packed {
    logic [LOG_W-1:0]  median_log;
    logic [LOG_W-1:0]  interval_log;
    logic [TIME_W-1:0] window_median;
    logic [TIME_W-1:0] interval;
  } iwm_result_t;

  // predictor state
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] ring [WINDOW];
  int                ring_fill;
  int                ring_head;

  // expected results in arrival order, held in a circular buffer
  iwm_result_t expected_results [EXP_DEPTH];
  int          exp_wr     = 0;
  int          exp_rd     = 0;
  int          mismatches = 0;

  // log1p(x) in unsigned 6.10: log2 by repeated squaring, then scaled by ln 2
  function automatic logic [LOG_W-1:0] log1p_q6_10(input logic [TIME_W-1:0] x);
    logic [TIME_W:0]   v;
    logic [63:0]       t;
    logic [63:0]       mant;
    logic [19:0]       frac;
    logic [63:0]       lg;
    logic [63:0]       prod;
    int                e;
    int                i;
    v = {1'b0, x} + 65'd1;
    if (v[TIME_W]) begin
      // x is all ones, v is exactly 2^64
      e = 64;
      t = 64'h8000_0000;
    end else begin
      e = 63;
      while (!v[e]) e--;
      mant = v[63:0] << (63 - e);
      t    = mant >> 32;
    end
    frac = '0;
    for (i = 0; i < FRAC_BITS; i++) begin
      t    = (t * t) >> 31;
      frac = {frac[18:0], 1'b0};
      if (t >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        t       = t >> 1;
      end
    end
    lg   = (64'(e) << FRAC_BITS) | 64'(frac);
    prod = lg * 64'(LN2_Q32) + (64'd1 << 41);
    return prod[57:42];
  endfunction

  // element count/2 of the sorted window, zero when empty
  function automatic logic [TIME_W-1:0] current_median();
    logic [TIME_W-1:0] ordered [WINDOW];
    logic [TIME_W-1:0] key;
    int                i;
    int                j;
    if (ring_fill == 0) return '0;
    for (i = 0; i < ring_fill; i++) ordered[i] = ring[(ring_head + i) % WINDOW];
    for (i = 1; i < ring_fill; i++) begin
      key = ordered[i];
      j   = i;
      while (j > 0 && ordered[j-1] > key) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    return ordered[ring_fill / 2];
  endfunction

  // advance the predictor by one accepted timestamp and store its result
  task automatic take_timestamp(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] span_us;
    iwm_result_t       res;
    span_us = '0;
    // zero previous time means no earlier event; not-later stamps leave the window alone
    if (last_time != '0 && stamp > last_time) begin
      span_us = stamp - last_time;
      if (ring_fill < WINDOW) begin
        ring[(ring_head + ring_fill) % WINDOW] = span_us;
        ring_fill++;
      end else begin
        ring[ring_head] = span_us;
        ring_head       = (ring_head + 1) % WINDOW;
      end
    end
    res.interval      = span_us;
    res.window_median = current_median();
    res.interval_log  = log1p_q6_10(span_us);
    res.median_log    = log1p_q6_10(res.window_median);
    last_time         = stamp;
    if (exp_wr - exp_rd >= EXP_DEPTH) begin
      if (mismatches < 10)
        $display("%0t MISMATCH: too many results outstanding", $realtime);
      mismatches++;
    end else begin
      expected_results[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t MISMATCH %s: expected %0h actual %0h", $realtime, label, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input iwm_result_t got);
    iwm_result_t want;
    if (exp_wr == exp_rd) begin
      if (mismatches < 10)
        $display("%0t MISMATCH: result transaction with none expected (%0h)", $realtime, got);
      mismatches++;
    end else begin
      want = expected_results[exp_rd % EXP_DEPTH];
      exp_rd++;
      check_field("interval", want.interval, got.interval);
      check_field("window_median", want.window_median, got.window_median);
      check_field("interval_log", 64'(want.interval_log), 64'(got.interval_log));
      check_field("median_log", 64'(want.median_log), 64'(got.median_log));
    end
  endtask

  // sample both channels at the edge and register the counts
  always @(posedge clk) begin
    if (!rst_n) begin
      last_time = '0;
      ring_fill = 0;
      ring_head = 0;
    end else begin
      if (in_tvalid && in_tready) take_timestamp(in_tdata);
      if (out_tvalid && out_tready) compare_result(out_tdata);
    end
    pending    <= exp_wr - exp_rd;
    fail_count <= mismatches;
  end

endmodule

// ----- bench/tb_interarrival_window_median_unit.sv -----
// Testbench top for the interarrival window median unit: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module tb_interarrival_window_median_unit;

  localparam int RANDOM_ITEMS = 550;
  localparam int STALL_LIMIT  = 8000;   // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 600;    // wait after the last expected result
  localparam int HOLD_CYCLES  = 1500;   // one long receiver hold-off
  localparam int HOLD_AFTER   = 150;    // results taken before the hold-off

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;

  int fail_count;
  int pending;
  int sender_burst   = 0;
  int receiver_burst = 0;

  // directed timestamps: startup, repeats, going back, extremes and wide steps
  logic [63:0] directed_times [19] = '{
    64'd0,                     // first event at time zero
    64'd0,                     // previous zero counts as no earlier event
    64'd5,                     // still no earlier event
    64'd10,                    // first positive interval
    64'd10,                    // equal time
    64'd3,                     // earlier time
    64'd4,                     // two entries, upper median
    64'd0,                     // back to zero
    64'd7,                     // no earlier event again
    64'd1,                     // earlier
    64'hFFFF_FFFF_FFFF_FFFF,   // largest interval
    64'h8000_0000_0000_0000,   // earlier
    64'h8000_0000_0000_0001,   // interval of one
    64'h8000_0001_0000_0001,   // interval 2^32
    64'h8000_0001_FFFF_FFFF,   // interval 2^32-2
    64'h8000_0002_0000_0000,
    64'h8000_0002_0000_0001,
    64'hFFFF_FFFF_FFFF_FFFE,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  interarrival_window_median_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  iwm_median_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, a few long, with gap-free bursts
  function automatic int pick_idle(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // offer one timestamp and hold it until the transaction completes
  task automatic send_time(input logic [63:0] stamp);
    int idle;
    idle = pick_idle(sender_burst);
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
  endtask

  // stimulus
  initial begin
    logic [63:0] stamp_us;
    logic [63:0] step_us;
    int          r;
    int          k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < $size(directed_times); k++) send_time(directed_times[k]);
    stamp_us = directed_times[$size(directed_times)-1];

    // mostly rising timestamps with assorted steps, plus repeats, rewinds and jumps
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        case ($urandom_range(0, 3))
          0:       step_us = 64'($urandom_range(1, 8));
          1:       step_us = 64'($urandom_range(1, 5000));
          2:       step_us = {$urandom, $urandom} >> $urandom_range(8, 63);
          default: step_us = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if (step_us == '0) step_us = 64'd1;
        stamp_us = stamp_us + step_us;
      end else if (r < 86) begin
        stamp_us = stamp_us;
      end else if (r < 92) begin
        stamp_us = (stamp_us == '0) ? '0 : {$urandom, $urandom} % stamp_us;
      end else if (r < 95) begin
        stamp_us = '0;
      end else begin
        stamp_us = {$urandom, $urandom};
      end
      send_time(stamp_us);
    end
    in_tvalid <= 1'b0;

    // let the checker see the last transaction, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int idle;
    int results_taken;
    bit held_off;
    results_taken = 0;
    held_off      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      idle = pick_idle(receiver_burst);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        idle     = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (idle > 0) begin
        out_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
